[hw/rtl/bfra_pkg.sv]
// Shared types and constants for the bounded FIFO running-average block.
`default_nettype none
package bfra_pkg;

   localparam int KIND_W   = 1;
   localparam int RECORD_W = 12;
   localparam int HEIGHT_W = 9;
   localparam int OCC_W    = 3;
   localparam int ENTRY_W  = RECORD_W + HEIGHT_W;

   localparam logic [KIND_W-1:0] KIND_INSERT = 1'b0;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_DIVIDE,
      ST_ROUND
   } state_type;

endpackage : bfra_pkg
`default_nettype wire

[hw/rtl/bfra_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module bfra_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 4,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule : bfra_ram
`default_nettype wire

[hw/rtl/bounded_fifo_running_average_top.sv]
// Top level: FIFO window of records with a running, rounded mean of heights.
//
//   channel  ports                       transfer
//   request  start, busy, req_*          start high and busy low at the clock edge
//   response rsp_strobe, rsp_*           rsp_strobe high for one cycle, always taken
//
// Remove: the request passes through ST_READ (oldest entry read from RAM), then the strobe.
// Insert: ST_READ, then ST_DIVIDE for the bit-serial divider that forms the mean,
// one quotient bit per cycle, then ST_ROUND, then the strobe.
// busy stays high from the transfer until the strobe; one item at a time.
// Synchronous reset empties the window; the RAM contents are not cleared.
`default_nettype none
module bounded_fifo_running_average_top #(
   parameter int WINDOW = 5
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [bfra_pkg::KIND_W-1:0]   req_kind,
   input  wire logic [bfra_pkg::RECORD_W-1:0] req_record_id,
   input  wire logic [bfra_pkg::HEIGHT_W-1:0] req_height,
   output logic                               rsp_strobe,
   output logic [bfra_pkg::HEIGHT_W-1:0]      rsp_average,
   output logic [bfra_pkg::RECORD_W-1:0]      rsp_removed_id,
   output logic [bfra_pkg::HEIGHT_W-1:0]      rsp_removed_height,
   output logic                               rsp_was_empty,
   output logic                               rsp_evicted,
   output logic [bfra_pkg::OCC_W-1:0]         rsp_occupancy
);

   localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W  = $clog2(WINDOW + 1);
   localparam int PTR_W  = CNT_W + 1;
   localparam int SUM_W  = bfra_pkg::HEIGHT_W + CNT_W;
   localparam int STEP_W = $clog2(SUM_W + 1);

   bfra_pkg::state_type state_ff, state_in;

   logic [IDX_W-1:0]                 oldest_ff, oldest_in;
   logic [CNT_W-1:0]                 count_ff, count_in;
   logic [SUM_W-1:0]                 sum_ff, sum_in;

   logic [bfra_pkg::KIND_W-1:0]      kind_ff, kind_in;
   logic [bfra_pkg::RECORD_W-1:0]    rec_ff, rec_in;
   logic [bfra_pkg::HEIGHT_W-1:0]    hgt_ff, hgt_in;

   logic [SUM_W-1:0]                 num_ff, num_in;
   logic [SUM_W-1:0]                 quot_ff, quot_in;
   logic [CNT_W-1:0]                 rem_ff, rem_in;
   logic [STEP_W-1:0]                step_ff, step_in;

   logic                             strobe_ff, strobe_in;
   logic [bfra_pkg::HEIGHT_W-1:0]    avg_ff, avg_in;
   logic [bfra_pkg::RECORD_W-1:0]    rid_ff, rid_in;
   logic [bfra_pkg::HEIGHT_W-1:0]    rh_ff, rh_in;
   logic                             empty_ff, empty_in;
   logic                             evict_ff, evict_in;

   logic                             accept;
   logic                             ram_wr_en;
   logic [IDX_W-1:0]                 ram_wr_addr;
   logic [bfra_pkg::ENTRY_W-1:0]     ram_wr_data;
   logic [bfra_pkg::ENTRY_W-1:0]     ram_rd_data;

   logic [bfra_pkg::RECORD_W-1:0]    old_rec;
   logic [bfra_pkg::HEIGHT_W-1:0]    old_hgt;
   logic                             full;
   logic [IDX_W-1:0]                 oldest_next;
   logic [PTR_W-1:0]                 tail_raw;
   logic [PTR_W-1:0]                 tail_wrap;
   logic [CNT_W:0]                   rem_shift;
   logic                             rem_ge;
   logic [CNT_W:0]                   rem_twice;
   logic                             round_up;
   logic [SUM_W-1:0]                 quot_rounded;

   assign accept = start && (state_ff == bfra_pkg::ST_IDLE);
   assign busy   = (state_ff != bfra_pkg::ST_IDLE);

   bfra_ram #(
      .WIDTH  (bfra_pkg::ENTRY_W),
      .DEPTH  (WINDOW),
      .ADDR_W (IDX_W)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (oldest_ff),
      .rd_data (ram_rd_data)
   );

   assign old_rec     = ram_rd_data[bfra_pkg::ENTRY_W-1:bfra_pkg::HEIGHT_W];
   assign old_hgt     = ram_rd_data[bfra_pkg::HEIGHT_W-1:0];
   assign full        = (count_ff == CNT_W'(WINDOW));
   assign oldest_next = (oldest_ff == IDX_W'(WINDOW - 1)) ? '0 : oldest_ff + 1'b1;
   assign tail_raw    = PTR_W'(oldest_ff) + PTR_W'(count_ff);
   assign tail_wrap   = (tail_raw >= PTR_W'(WINDOW)) ? tail_raw - PTR_W'(WINDOW) : tail_raw;

   assign rem_shift    = {rem_ff, num_ff[SUM_W-1]};
   assign rem_ge       = (rem_shift >= {1'b0, count_ff});
   assign rem_twice    = {rem_ff, 1'b0};
   assign round_up     = (rem_twice > {1'b0, count_ff})
                         || ((rem_twice == {1'b0, count_ff}) && quot_ff[0]);
   assign quot_rounded = quot_ff + SUM_W'(round_up);

   always_comb begin
      state_in    = state_ff;
      oldest_in   = oldest_ff;
      count_in    = count_ff;
      sum_in      = sum_ff;
      kind_in     = kind_ff;
      rec_in      = rec_ff;
      hgt_in      = hgt_ff;
      num_in      = num_ff;
      quot_in     = quot_ff;
      rem_in      = rem_ff;
      step_in     = step_ff;
      strobe_in   = 1'b0;
      avg_in      = avg_ff;
      rid_in      = rid_ff;
      rh_in       = rh_ff;
      empty_in    = empty_ff;
      evict_in    = evict_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = full ? oldest_ff : IDX_W'(tail_wrap);
      ram_wr_data = {rec_ff, hgt_ff};

      unique case (state_ff)
         bfra_pkg::ST_IDLE: begin
            if (start) begin
               kind_in  = req_kind;
               rec_in   = req_record_id;
               hgt_in   = req_height;
               state_in = bfra_pkg::ST_READ;
            end
         end
         bfra_pkg::ST_READ: begin
            avg_in   = '0;
            rid_in   = '0;
            rh_in    = '0;
            empty_in = 1'b0;
            evict_in = 1'b0;
            if (kind_ff == bfra_pkg::KIND_REMOVE) begin
               strobe_in = 1'b1;
               state_in  = bfra_pkg::ST_IDLE;
               if (count_ff == '0) begin
                  empty_in = 1'b1;
               end else begin
                  rid_in    = old_rec;
                  rh_in     = old_hgt;
                  oldest_in = oldest_next;
                  count_in  = count_ff - 1'b1;
                  sum_in    = sum_ff - SUM_W'(old_hgt);
               end
            end else begin
               ram_wr_en = 1'b1;
               if (full) begin
                  evict_in  = 1'b1;
                  oldest_in = oldest_next;
                  sum_in    = sum_ff - SUM_W'(old_hgt) + SUM_W'(hgt_ff);
                  num_in    = sum_ff - SUM_W'(old_hgt) + SUM_W'(hgt_ff);
               end else begin
                  count_in  = count_ff + 1'b1;
                  sum_in    = sum_ff + SUM_W'(hgt_ff);
                  num_in    = sum_ff + SUM_W'(hgt_ff);
               end
               quot_in  = '0;
               rem_in   = '0;
               step_in  = STEP_W'(SUM_W);
               state_in = bfra_pkg::ST_DIVIDE;
            end
         end
         bfra_pkg::ST_DIVIDE: begin
            num_in  = {num_ff[SUM_W-2:0], 1'b0};
            quot_in = {quot_ff[SUM_W-2:0], rem_ge};
            rem_in  = rem_ge ? CNT_W'(rem_shift - {1'b0, count_ff}) : CNT_W'(rem_shift);
            step_in = step_ff - 1'b1;
            if (step_ff == STEP_W'(1)) begin
               state_in = bfra_pkg::ST_ROUND;
            end
         end
         bfra_pkg::ST_ROUND: begin
            avg_in    = quot_rounded[bfra_pkg::HEIGHT_W-1:0];
            strobe_in = 1'b1;
            state_in  = bfra_pkg::ST_IDLE;
         end
         default: begin
            state_in = bfra_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= bfra_pkg::ST_IDLE;
         oldest_ff <= '0;
         count_ff  <= '0;
         sum_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         oldest_ff <= oldest_in;
         count_ff  <= count_in;
         sum_ff    <= sum_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      rec_ff   <= rec_in;
      hgt_ff   <= hgt_in;
      num_ff   <= num_in;
      quot_ff  <= quot_in;
      rem_ff   <= rem_in;
      step_ff  <= step_in;
      avg_ff   <= avg_in;
      rid_ff   <= rid_in;
      rh_ff    <= rh_in;
      empty_ff <= empty_in;
      evict_ff <= evict_in;
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_average        = avg_ff;
   assign rsp_removed_id     = rid_ff;
   assign rsp_removed_height = rh_ff;
   assign rsp_was_empty      = empty_ff;
   assign rsp_evicted        = evict_ff;
   assign rsp_occupancy      = bfra_pkg::OCC_W'(count_ff);

endmodule : bounded_fifo_running_average_top
`default_nettype wire
